// ----- sv/ffea_pkg.sv -----
package ffea_pkg;

    // Table geometry.
    localparam int MAX_EXTENTS = 16;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

    // Operation codes.
    localparam logic [1:0] OP_ALLOC       = 2'd0;
    localparam logic [1:0] OP_RELEASE     = 2'd1;
    localparam logic [1:0] OP_RELEASE_ALL = 2'd2;
    localparam logic [1:0] OP_PROBE       = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_SPACE    = 3'd1;
    localparam logic [2:0] ST_BAD_ADDR    = 3'd2;
    localparam logic [2:0] ST_DOUBLE_FREE = 3'd3;
    localparam logic [2:0] ST_FULL        = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_REGION_BASE   = 1'b0;
    localparam logic CFG_REGION_LENGTH = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] request_length;
        logic [31:0] release_address;
    } req_t;

    typedef struct packed {
        logic [31:0] block_address;
        logic [2:0]  status;
    } res_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
    } ext_t;

endpackage

// ----- sv/first_fit_extent_allocator_core.sv -----
// First-fit extent allocator.
// Command channel: an operation beat is taken when start is high and busy is
// low. Operations are allocate, release, release all and probe. Each beat
// yields exactly one result beat on result, marked by done for one cycle;
// the receiver cannot stall it.
// Configuration channel: cfg_valid/cfg_ready with cfg_index (0 region base,
// 1 region length) and cfg_data. cfg_ready is always high; write only while
// the block is idle.
// The free list lives in a 16-entry synchronous memory with registered reads.
// Allocate, probe and release walk the table one entry at a time, each
// entry read (S_SCAN_RD) and then compared (S_SCAN_CHK); release all and
// a release out of the region finish without a walk. Removing or
// inserting an entry adds a move of the tail, one read and one write per
// moved entry. One operation is in flight at a time.
// Reset empties the table and clears the region registers; no clearing pass
// is needed since only entries below the count are ever read.
module first_fit_extent_allocator_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ffea_pkg::req_t       req,
    output logic                 done,
    output ffea_pkg::res_t       result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_REL_DEC,
        S_DOWN_RD,
        S_DOWN_WR,
        S_UP_RD,
        S_UP_WR
    } state_t;

    state_t                            state_reg;
    ffea_pkg::req_t                    req_reg;
    ffea_pkg::res_t                    result_reg;
    logic                              done_reg;
    logic [31:0]                       region_base_reg;
    logic [31:0]                       region_length_reg;
    logic [ffea_pkg::CNT_W-1:0]        count_reg;
    logic [ffea_pkg::CNT_W-1:0]        idx_reg;
    logic [ffea_pkg::CNT_W-1:0]        pos_reg;
    ffea_pkg::ext_t                    prev_reg;
    ffea_pkg::ext_t                    nxt_reg;
    logic                              has_next_reg;
    ffea_pkg::ext_t                    rd_data_reg;

    // Table memory and its port controls.
    ffea_pkg::ext_t                    mem [ffea_pkg::MAX_EXTENTS];
    logic [ffea_pkg::IDX_W-1:0]        rd_addr;
    logic                              wr_en;
    logic [ffea_pkg::IDX_W-1:0]        wr_addr;
    ffea_pkg::ext_t                    wr_data;

    logic                              accept;
    logic [ffea_pkg::CNT_W-1:0]        idx_inc;
    logic [ffea_pkg::CNT_W-1:0]        idx_dec;
    logic                              scan_end;
    logic                              fits;
    logic                              at_or_above;
    logic [31:0]                       alloc_rem;
    logic [32:0]                       in_end;
    logic [32:0]                       region_end;
    logic                              bad_addr;
    logic                              has_prev;
    logic [32:0]                       prev_end;
    logic [32:0]                       next_sum;
    logic                              dbl_free;
    logic                              merge_next;
    logic [31:0]                       new_len;
    logic [32:0]                       prev_sum;
    logic                              merge_prev;
    logic                              table_full;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // Scan and move arithmetic.
    assign idx_inc     = idx_reg + 1'b1;
    assign idx_dec     = idx_reg - 1'b1;
    assign scan_end    = (idx_reg == count_reg);
    assign fits        = (rd_data_reg.length >= req_reg.request_length);
    assign at_or_above = (rd_data_reg.start >= req_reg.release_address);
    assign alloc_rem   = rd_data_reg.length - req_reg.request_length;

    // Release range check against the region, taken on the command beat.
    assign in_end     = {1'b0, req.release_address} + {1'b0, req.request_length};
    assign region_end = {1'b0, region_base_reg} + {1'b0, region_length_reg};
    assign bad_addr   = (req.release_address < region_base_reg) || (in_end > region_end);

    // Release decision against the previous and next neighbors.
    assign has_prev   = (idx_reg != '0);
    assign prev_end   = {1'b0, prev_reg.start} + {1'b0, prev_reg.length};
    assign next_sum   = {1'b0, req_reg.request_length} + {1'b0, nxt_reg.length};
    assign dbl_free   = (has_prev && (prev_end > {1'b0, req_reg.release_address}))
                     || (has_next_reg && ({1'b0, nxt_reg.start} <
                         ({1'b0, req_reg.release_address} + {1'b0, req_reg.request_length})));
    assign merge_next = has_next_reg && !next_sum[32]
                     && (({1'b0, req_reg.release_address} + {1'b0, req_reg.request_length})
                         == {1'b0, nxt_reg.start});
    assign new_len    = merge_next ? next_sum[31:0] : req_reg.request_length;
    assign prev_sum   = {1'b0, prev_reg.length} + {1'b0, new_len};
    assign merge_prev = has_prev && !prev_sum[32]
                     && (prev_end == {1'b0, req_reg.release_address});
    assign table_full = (count_reg == ffea_pkg::CNT_W'(ffea_pkg::MAX_EXTENTS));

    // Memory port selection.
    always_comb
    begin
        rd_addr = idx_reg[ffea_pkg::IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[ffea_pkg::IDX_W-1:0];
        wr_data = rd_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req.op == ffea_pkg::OP_RELEASE_ALL)
                begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = '{start: region_base_reg, length: region_length_reg};
                end
            end
            S_SCAN_CHK:
            begin
                if (req_reg.op == ffea_pkg::OP_ALLOC && fits && alloc_rem != '0)
                begin
                    wr_en   = 1'b1;
                    wr_data = '{start: rd_data_reg.start + req_reg.request_length,
                                length: alloc_rem};
                end
            end
            S_REL_DEC:
            begin
                if (!dbl_free && merge_prev)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_dec[ffea_pkg::IDX_W-1:0];
                    wr_data = '{start: prev_reg.start, length: prev_sum[31:0]};
                end
                else if (!dbl_free && merge_next)
                begin
                    wr_en   = 1'b1;
                    wr_data = '{start: req_reg.release_address, length: new_len};
                end
            end
            S_DOWN_RD:
            begin
                rd_addr = idx_inc[ffea_pkg::IDX_W-1:0];
            end
            S_DOWN_WR:
            begin
                wr_en = 1'b1;
            end
            S_UP_RD:
            begin
                rd_addr = idx_dec[ffea_pkg::IDX_W-1:0];
                if (idx_reg == pos_reg)
                begin
                    wr_en   = 1'b1;
                    wr_data = '{start: req_reg.release_address,
                                length: req_reg.request_length};
                end
            end
            S_UP_WR:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Synchronous table memory.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg   <= '0;
            region_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ffea_pkg::CFG_REGION_BASE:   region_base_reg   <= cfg_data;
                ffea_pkg::CFG_REGION_LENGTH: region_length_reg <= cfg_data;
                default:                     region_base_reg   <= region_base_reg;
            endcase
        end
    end

    // Operation sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            count_reg    <= '0;
            idx_reg      <= '0;
            pos_reg      <= '0;
            has_next_reg <= 1'b0;
            result_reg   <= '0;
            req_reg      <= '0;
            prev_reg     <= '0;
            nxt_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg <= req;
                        idx_reg <= '0;
                        if (req.op == ffea_pkg::OP_RELEASE_ALL)
                        begin
                            count_reg  <= ffea_pkg::CNT_W'(1);
                            result_reg <= '{block_address: '0, status: ffea_pkg::ST_OK};
                            done_reg   <= 1'b1;
                        end
                        else if (req.op == ffea_pkg::OP_RELEASE && bad_addr)
                        begin
                            result_reg <= '{block_address: '0,
                                            status: ffea_pkg::ST_BAD_ADDR};
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD:
                begin
                    if (scan_end)
                    begin
                        if (req_reg.op == ffea_pkg::OP_RELEASE)
                        begin
                            has_next_reg <= 1'b0;
                            state_reg    <= S_REL_DEC;
                        end
                        else
                        begin
                            result_reg <= '{block_address: '0,
                                            status: ffea_pkg::ST_NO_SPACE};
                            done_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK:
                begin
                    if (req_reg.op == ffea_pkg::OP_RELEASE)
                    begin
                        if (at_or_above)
                        begin
                            nxt_reg      <= rd_data_reg;
                            has_next_reg <= 1'b1;
                            state_reg    <= S_REL_DEC;
                        end
                        else
                        begin
                            prev_reg  <= rd_data_reg;
                            idx_reg   <= idx_inc;
                            state_reg <= S_SCAN_RD;
                        end
                    end
                    else if (fits)
                    begin
                        result_reg <= '{block_address: rd_data_reg.start,
                                        status: ffea_pkg::ST_OK};
                        if (req_reg.op == ffea_pkg::OP_ALLOC && alloc_rem == '0)
                        begin
                            state_reg <= S_DOWN_RD;
                        end
                        else
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_REL_DEC:
                begin
                    result_reg.block_address <= '0;
                    if (dbl_free)
                    begin
                        result_reg.status <= ffea_pkg::ST_DOUBLE_FREE;
                        done_reg          <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                    else if (merge_prev)
                    begin
                        result_reg.status <= ffea_pkg::ST_OK;
                        if (merge_next)
                        begin
                            state_reg <= S_DOWN_RD;
                        end
                        else
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (merge_next)
                    begin
                        result_reg.status <= ffea_pkg::ST_OK;
                        done_reg          <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                    else if (table_full)
                    begin
                        result_reg.status <= ffea_pkg::ST_FULL;
                        done_reg          <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                    else
                    begin
                        result_reg.status <= ffea_pkg::ST_OK;
                        pos_reg           <= idx_reg;
                        idx_reg           <= count_reg;
                        state_reg         <= S_UP_RD;
                    end
                end
                // Remove entry idx by moving the tail down one place.
                S_DOWN_RD:
                begin
                    if (idx_inc >= count_reg)
                    begin
                        count_reg <= count_reg - 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_DOWN_WR;
                    end
                end
                S_DOWN_WR:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= S_DOWN_RD;
                end
                // Open a slot at pos by moving the tail up one place.
                S_UP_RD:
                begin
                    if (idx_reg == pos_reg)
                    begin
                        count_reg <= count_reg + 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_UP_WR;
                    end
                end
                S_UP_WR:
                begin
                    idx_reg   <= idx_dec;
                    state_reg <= S_UP_RD;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The extent count never exceeds the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ffea_pkg::CNT_W'(ffea_pkg::MAX_EXTENTS))
        else $error("extent count beyond table size");

    // A failing beat never carries an address.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ffea_pkg::ST_OK) |-> (result.block_address == '0))
        else $error("failure result with nonzero address");

    // Release operations that finish after a table walk report address zero.
    a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && state_reg == S_IDLE && $past(state_reg) != S_IDLE
         && (req_reg.op == ffea_pkg::OP_RELEASE || req_reg.op == ffea_pkg::OP_RELEASE_ALL))
        |-> (result.block_address == '0))
        else $error("release result with nonzero address");

    // A table insert only starts when a slot is free.
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP_RD) |-> !table_full)
        else $error("insert into full table");
`endif

endmodule
